// File: rtl/core/pms_pkg.sv
package pms_pkg;

    localparam int MOVE_W  = 32;
    localparam int SCORE_W = 5;
    localparam int KIND_W  = 3;

    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_START  = 2'd2;
    localparam logic [1:0] MODE_NEXT   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [SCORE_W-1:0] CAPTURE_BASE = 5'd15;

    // Captures score 15 + 2*captured - mover (range 8..29); quiet moves score 0.
    function automatic logic [SCORE_W-1:0] score_of(
        input logic              is_capture,
        input logic [KIND_W-1:0] captured_kind,
        input logic [KIND_W-1:0] mover_kind
    );
        logic [SCORE_W-1:0] s;
        s = CAPTURE_BASE + {1'b0, captured_kind, 1'b0} - {2'b00, mover_kind};
        return is_capture ? s : '0;
    endfunction

endpackage

// File: rtl/core/pms_if.sv
interface pms_cmd_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 mode;
    logic [pms_pkg::MOVE_W-1:0] move_word;
    logic                       is_capture;
    logic [pms_pkg::KIND_W-1:0] captured_kind;
    logic [pms_pkg::KIND_W-1:0] mover_kind;
    logic [pms_pkg::MOVE_W-1:0] priority_move;
    logic                       sort_by_priority;

    modport source (
        output valid, mode, move_word, is_capture, captured_kind, mover_kind,
               priority_move, sort_by_priority,
        input  ready
    );
    modport sink (
        input  valid, mode, move_word, is_capture, captured_kind, mover_kind,
               priority_move, sort_by_priority,
        output ready
    );
endinterface

interface pms_res_if;
    logic                       valid;
    logic                       ready;
    logic [pms_pkg::MOVE_W-1:0] out_move;
    logic                       has_more;
    logic [1:0]                 status;

    modport source (
        output valid, out_move, has_more, status,
        input  ready
    );
    modport sink (
        input  valid, out_move, has_more, status,
        output ready
    );
endinterface

// File: rtl/core/pms_ram.sv
module pms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/priority_move_selector_top.sv
// Clear and start sweep the used-mark memory before they return a result.
// Append and a priority-move next go from idle straight to emit; a list-order next reads its entry first.
// A priority-order scan makes one memory read per entry.
// One transaction is processed at a time; the result register frees the input.
// Reset is synchronous, active low, and is followed by a sweep of the
// used-mark memory during which no transaction is accepted.
module priority_move_selector_top #(
    parameter int MAX_ENTRIES = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pms_cmd_if.sink    i_cmd,
    pms_res_if.source  o_res
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int DW = pms_pkg::MOVE_W + pms_pkg::SCORE_W;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_LREAD,
        S_SCAN,
        S_EMIT
    } t_state;

    t_state                       r_state;
    logic [CW-1:0]                r_list_count;
    logic [CW-1:0]                r_taken_count;
    logic [pms_pkg::MOVE_W-1:0]   r_held_prio;
    logic                         r_order;
    logic [AW-1:0]                r_sweep;
    logic                         r_emit_after;
    logic [CW-1:0]                r_scan_idx;
    logic                         r_pend_valid;
    logic [AW-1:0]                r_pend_idx;
    logic                         r_found;
    logic [AW-1:0]                r_best_idx;
    logic [pms_pkg::SCORE_W-1:0]  r_best_score;
    logic [pms_pkg::MOVE_W-1:0]   r_best_move;
    logic [pms_pkg::MOVE_W-1:0]   r_res_move;
    logic [1:0]                   r_res_status;
    logic                         r_out_valid;
    logic [pms_pkg::MOVE_W-1:0]   r_out_move;
    logic                         r_out_has_more;
    logic [1:0]                   r_out_status;

    logic                         cmd_fire;
    logic                         out_fire;
    logic                         append_ok;
    logic                         scan_done;
    logic                         cand;
    logic                         data_we;
    logic [AW-1:0]                data_raddr;
    logic [DW-1:0]                data_wdata;
    logic [DW-1:0]                data_rd;
    logic [pms_pkg::MOVE_W-1:0]   rd_move;
    logic [pms_pkg::SCORE_W-1:0]  rd_score;
    logic                         used_we;
    logic [AW-1:0]                used_waddr;
    logic                         used_wdata;
    logic                         used_rd;

    assign cmd_fire  = i_cmd.valid && i_cmd.ready;
    assign out_fire  = r_out_valid && o_res.ready;
    assign append_ok = cmd_fire && (i_cmd.mode == pms_pkg::MODE_APPEND)
                       && (r_list_count != CW'(MAX_ENTRIES));
    assign scan_done = (r_scan_idx == r_list_count) && !r_pend_valid;
    assign rd_move   = data_rd[DW-1:pms_pkg::SCORE_W];
    assign rd_score  = data_rd[pms_pkg::SCORE_W-1:0];

    // Entry at r_pend_idx was read last cycle; test it against the running best.
    assign cand = r_pend_valid && !used_rd && (rd_move != '0) && (rd_move != r_held_prio)
                  && (!r_found || (rd_score > r_best_score));

    assign data_we    = append_ok;
    assign data_wdata = {i_cmd.move_word,
                         pms_pkg::score_of(i_cmd.is_capture, i_cmd.captured_kind,
                                           i_cmd.mover_kind)};
    assign data_raddr = (r_state == S_SCAN) ? r_scan_idx[AW-1:0] : r_taken_count[AW-1:0];

    always_comb begin
        used_we    = 1'b0;
        used_waddr = r_list_count[AW-1:0];
        used_wdata = 1'b0;
        if (r_state == S_SWEEP) begin
            used_we    = 1'b1;
            used_waddr = r_sweep;
        end else if (append_ok) begin
            used_we    = 1'b1;
        end else if ((r_state == S_SCAN) && scan_done && r_found) begin
            used_we    = 1'b1;
            used_waddr = r_best_idx;
            used_wdata = 1'b1;
        end
    end

    pms_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_ENTRIES)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (data_we),
        .i_waddr (r_list_count[AW-1:0]),
        .i_wdata (data_wdata),
        .i_raddr (data_raddr),
        .o_rdata (data_rd)
    );

    pms_ram #(
        .WIDTH (1),
        .DEPTH (MAX_ENTRIES)
    ) u_used_ram (
        .i_clk   (i_clk),
        .i_we    (used_we),
        .i_waddr (used_waddr),
        .i_wdata (used_wdata),
        .i_raddr (r_scan_idx[AW-1:0]),
        .o_rdata (used_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_SWEEP;
            r_list_count  <= '0;
            r_taken_count <= '0;
            r_held_prio   <= '0;
            r_order       <= 1'b0;
            r_sweep       <= '0;
            r_emit_after  <= 1'b0;
            r_scan_idx    <= '0;
            r_pend_valid  <= 1'b0;
            r_found       <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (out_fire) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_SWEEP: begin
                    r_sweep <= r_sweep + AW'(1);
                    if (r_sweep == AW'(MAX_ENTRIES - 1)) begin
                        r_state <= r_emit_after ? S_EMIT : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (cmd_fire) begin
                        r_res_move   <= '0;
                        r_res_status <= pms_pkg::ST_OK;
                        r_state      <= S_EMIT;
                        case (i_cmd.mode)
                            pms_pkg::MODE_CLEAR: begin
                                r_list_count  <= '0;
                                r_taken_count <= '0;
                                r_sweep       <= '0;
                                r_emit_after  <= 1'b1;
                                r_state       <= S_SWEEP;
                            end
                            pms_pkg::MODE_APPEND: begin
                                if (append_ok) begin
                                    r_list_count <= r_list_count + CW'(1);
                                end else begin
                                    r_res_status <= pms_pkg::ST_FULL;
                                end
                            end
                            pms_pkg::MODE_START: begin
                                r_held_prio   <= i_cmd.priority_move;
                                r_order       <= i_cmd.sort_by_priority;
                                r_taken_count <= '0;
                                r_sweep       <= '0;
                                r_emit_after  <= 1'b1;
                                r_state       <= S_SWEEP;
                                if (r_list_count == '0) begin
                                    r_res_status <= pms_pkg::ST_EMPTY;
                                end
                            end
                            default: begin
                                if (!r_order) begin
                                    if (r_taken_count < r_list_count) begin
                                        r_state <= S_LREAD;
                                    end else begin
                                        r_res_status <= pms_pkg::ST_EMPTY;
                                    end
                                end else if ((r_taken_count == '0) && (r_held_prio != '0)) begin
                                    r_res_move    <= r_held_prio;
                                    r_taken_count <= r_taken_count + CW'(1);
                                end else if (r_list_count == '0) begin
                                    r_res_status <= pms_pkg::ST_EMPTY;
                                end else begin
                                    r_scan_idx   <= '0;
                                    r_pend_valid <= 1'b0;
                                    r_found      <= 1'b0;
                                    r_state      <= S_SCAN;
                                end
                            end
                        endcase
                    end
                end
                S_LREAD: begin
                    r_res_move    <= rd_move;
                    r_taken_count <= r_taken_count + CW'(1);
                    r_state       <= S_EMIT;
                end
                S_SCAN: begin
                    if (r_scan_idx != r_list_count) begin
                        r_pend_valid <= 1'b1;
                        r_pend_idx   <= r_scan_idx[AW-1:0];
                        r_scan_idx   <= r_scan_idx + CW'(1);
                    end else begin
                        r_pend_valid <= 1'b0;
                    end
                    if (cand) begin
                        r_found      <= 1'b1;
                        r_best_idx   <= r_pend_idx;
                        r_best_score <= rd_score;
                        r_best_move  <= rd_move;
                    end
                    if (scan_done) begin
                        r_state <= S_EMIT;
                        if (r_found) begin
                            r_res_move    <= r_best_move;
                            r_taken_count <= r_taken_count + CW'(1);
                        end else begin
                            r_res_status <= pms_pkg::ST_EMPTY;
                        end
                    end
                end
                S_EMIT: begin
                    if (!r_out_valid || out_fire) begin
                        r_out_valid    <= 1'b1;
                        r_out_move     <= r_res_move;
                        r_out_has_more <= (r_taken_count < r_list_count);
                        r_out_status   <= r_res_status;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_cmd.ready    = (r_state == S_IDLE);
    assign o_res.valid    = r_out_valid;
    assign o_res.out_move = r_out_move;
    assign o_res.has_more = r_out_has_more;
    assign o_res.status   = r_out_status;

endmodule

// File: bench/priority_move_selector_top_tb.sv
`timescale 1ns / 100ps

module priority_move_selector_top_tb;

    localparam int LIST_DEPTH    = 256;
    localparam int BASE_SCORE    = 15;
    localparam int VICTIM_WEIGHT = 2;
    localparam int RAND_ITEMS    = 650;
    localparam int CYCLE_LIMIT   = 1_000_000;

    typedef struct packed {
        logic [1:0]                 mode;
        logic [pms_pkg::MOVE_W-1:0] move_word;
        logic                       is_capture;
        logic [pms_pkg::KIND_W-1:0] captured_kind;
        logic [pms_pkg::KIND_W-1:0] mover_kind;
        logic [pms_pkg::MOVE_W-1:0] priority_move;
        logic                       sort_by_priority;
    } t_cmd;

    typedef struct packed {
        logic [pms_pkg::MOVE_W-1:0] out_move;
        logic                       has_more;
        logic [1:0]                 status;
    } t_res;

    typedef struct {
        t_cmd c;
        bit   typed;
        t_res r;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    pms_cmd_if cmd_if ();
    pms_res_if res_if ();

    priority_move_selector_top #(
        .MAX_ENTRIES(LIST_DEPTH)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_if),
        .o_res  (res_if)
    );

    // Shadow copy of the selector's list and walk state.
    logic [pms_pkg::MOVE_W-1:0]  mdl_moves  [LIST_DEPTH];
    logic [pms_pkg::SCORE_W-1:0] mdl_scores [LIST_DEPTH];
    bit                          mdl_used   [LIST_DEPTH];
    int                          mdl_count;
    int                          mdl_taken;
    logic [pms_pkg::MOVE_W-1:0]  mdl_prio;
    bit                          mdl_sorted;

    t_res                       pending_results[$];
    t_dir_row                   dir_tab[$];
    logic [pms_pkg::MOVE_W-1:0] recent_moves[$];

    int   sent_count;
    int   got_count;
    int   err_count;
    int   idle_pct;
    int   stall_pct;
    int   cycle_cnt;
    bit   exp_typed;
    t_res exp_given;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    task automatic compute_selection(input t_cmd c, output t_res r);
        int best_idx;
        int best_sc;
        r.out_move = '0;
        r.status   = pms_pkg::ST_OK;
        case (c.mode)
            pms_pkg::MODE_CLEAR: begin
                mdl_count = 0;
                mdl_taken = 0;
                foreach (mdl_used[i]) mdl_used[i] = 1'b0;
            end
            pms_pkg::MODE_APPEND: begin
                if (mdl_count >= LIST_DEPTH) begin
                    r.status = pms_pkg::ST_FULL;
                end else begin
                    mdl_moves[mdl_count]  = c.move_word;
                    mdl_scores[mdl_count] = c.is_capture ?
                        pms_pkg::SCORE_W'(BASE_SCORE + VICTIM_WEIGHT * int'(c.captured_kind)
                                          - int'(c.mover_kind)) : '0;
                    mdl_used[mdl_count]   = 1'b0;
                    mdl_count++;
                end
            end
            pms_pkg::MODE_START: begin
                mdl_prio   = c.priority_move;
                mdl_sorted = c.sort_by_priority;
                mdl_taken  = 0;
                foreach (mdl_used[i]) mdl_used[i] = 1'b0;
                if (mdl_count == 0) r.status = pms_pkg::ST_EMPTY;
            end
            default: begin
                if (!mdl_sorted) begin
                    if (mdl_taken < mdl_count) begin
                        r.out_move = mdl_moves[mdl_taken];
                        mdl_taken++;
                    end else begin
                        r.status = pms_pkg::ST_EMPTY;
                    end
                end else if (mdl_taken == 0 && mdl_prio != '0) begin
                    r.out_move = mdl_prio;
                    mdl_taken++;
                end else begin
                    // Strictly greater keeps the lowest index on a score tie.
                    best_idx = -1;
                    best_sc  = -1;
                    for (int i = 0; i < mdl_count; i++) begin
                        if (!mdl_used[i] && mdl_moves[i] != '0 && mdl_moves[i] != mdl_prio
                                && int'(mdl_scores[i]) > best_sc) begin
                            best_sc  = int'(mdl_scores[i]);
                            best_idx = i;
                        end
                    end
                    if (best_idx >= 0) begin
                        mdl_used[best_idx] = 1'b1;
                        r.out_move = mdl_moves[best_idx];
                        mdl_taken++;
                    end else begin
                        r.status = pms_pkg::ST_EMPTY;
                    end
                end
            end
        endcase
        r.has_more = (mdl_taken < mdl_count);
    endtask

    // Prediction and checking share one block so a push always precedes a pop.
    always @(posedge i_clk) begin
        t_cmd c;
        t_res p;
        t_res e;
        t_res got;
        if (i_rst_n) begin
            if (cmd_if.valid && cmd_if.ready) begin
                c.mode             = cmd_if.mode;
                c.move_word        = cmd_if.move_word;
                c.is_capture       = cmd_if.is_capture;
                c.captured_kind    = cmd_if.captured_kind;
                c.mover_kind       = cmd_if.mover_kind;
                c.priority_move    = cmd_if.priority_move;
                c.sort_by_priority = cmd_if.sort_by_priority;
                compute_selection(c, p);
                pending_results.push_back(exp_typed ? exp_given : p);
            end
            if (res_if.valid && res_if.ready) begin
                got_count++;
                got.out_move = res_if.out_move;
                got.has_more = res_if.has_more;
                got.status   = res_if.status;
                if (pending_results.size() == 0) begin
                    $error("result transaction with no expectation pending");
                    err_count++;
                end else begin
                    e = pending_results.pop_front();
                    if (got.out_move !== e.out_move) begin
                        $error("out_move: expected %h, actual %h", e.out_move, got.out_move);
                        err_count++;
                    end
                    if (got.has_more !== e.has_more) begin
                        $error("has_more: expected %b, actual %b", e.has_more, got.has_more);
                        err_count++;
                    end
                    if (got.status !== e.status) begin
                        $error("status: expected %0d, actual %0d", e.status, got.status);
                        err_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic send_cmd(input t_cmd c, input bit typed, input t_res r);
        while ($urandom_range(0, 99) < idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_if.valid            <= 1'b1;
        cmd_if.mode             <= c.mode;
        cmd_if.move_word        <= c.move_word;
        cmd_if.is_capture       <= c.is_capture;
        cmd_if.captured_kind    <= c.captured_kind;
        cmd_if.mover_kind       <= c.mover_kind;
        cmd_if.priority_move    <= c.priority_move;
        cmd_if.sort_by_priority <= c.sort_by_priority;
        exp_typed               <= typed;
        exp_given               <= r;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        sent_count++;
    endtask

    task automatic add_row(input logic [1:0] mode, input logic [pms_pkg::MOVE_W-1:0] mv,
                           input logic cap, input logic [pms_pkg::KIND_W-1:0] victim,
                           input logic [pms_pkg::KIND_W-1:0] attacker,
                           input logic [pms_pkg::MOVE_W-1:0] prio,
                           input logic sortp, input bit typed,
                           input logic [pms_pkg::MOVE_W-1:0] om,
                           input logic hm, input logic [1:0] st);
        t_dir_row row;
        row.c = '{mode, mv, cap, victim, attacker, prio, sortp};
        row.typed = typed;
        row.r = '{om, hm, st};
        dir_tab.push_back(row);
    endtask

    function automatic t_cmd rand_cmd(input logic [1:0] mode);
        t_cmd c;
        c.mode             = mode;
        c.move_word        = $urandom();
        c.is_capture       = 1'($urandom_range(0, 1));
        c.captured_kind    = 3'($urandom_range(0, 7));
        c.mover_kind       = 3'($urandom_range(0, 7));
        c.priority_move    = $urandom();
        c.sort_by_priority = 1'($urandom_range(0, 1));
        return c;
    endfunction

    // Null moves and repeats of earlier moves make ties and exclusions likely.
    function automatic logic [pms_pkg::MOVE_W-1:0] pick_word();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8) return '0;
        if (roll < 25 && recent_moves.size() > 0)
            return recent_moves[$urandom_range(0, recent_moves.size() - 1)];
        return $urandom();
    endfunction

    function automatic logic [pms_pkg::MOVE_W-1:0] pick_prio();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 30) return '0;
        if (roll < 65 && recent_moves.size() > 0)
            return recent_moves[$urandom_range(0, recent_moves.size() - 1)];
        return $urandom();
    endfunction

    // Clear (optionally), fill, then one or two start-and-walk passes.
    task automatic run_walk(input int n_app, input bit do_clear, input int walk_len);
        t_cmd c;
        t_res none;
        int   n_next;
        none = '0;
        if (do_clear) begin
            recent_moves.delete();
            send_cmd(rand_cmd(pms_pkg::MODE_CLEAR), 1'b0, none);
        end
        repeat (n_app) begin
            c = rand_cmd(pms_pkg::MODE_APPEND);
            c.move_word = pick_word();
            recent_moves.push_back(c.move_word);
            send_cmd(c, 1'b0, none);
        end
        repeat ($urandom_range(1, 2)) begin
            c = rand_cmd(pms_pkg::MODE_START);
            c.priority_move = pick_prio();
            send_cmd(c, 1'b0, none);
            n_next = (walk_len >= 0) ? walk_len : n_app + $urandom_range(0, 3);
            repeat (n_next) send_cmd(rand_cmd(pms_pkg::MODE_NEXT), 1'b0, none);
        end
    endtask

    initial begin
        t_res none;
        int   phase_end;
        none                    = '0;
        i_rst_n                 = 1'b0;
        cmd_if.valid            = 1'b0;
        cmd_if.mode             = pms_pkg::MODE_CLEAR;
        cmd_if.move_word        = '0;
        cmd_if.is_capture       = 1'b0;
        cmd_if.captured_kind    = '0;
        cmd_if.mover_kind       = '0;
        cmd_if.priority_move    = '0;
        cmd_if.sort_by_priority = 1'b0;
        exp_typed               = 1'b0;
        exp_given               = '0;
        idle_pct                = 0;
        stall_pct               = 0;
        foreach (mdl_used[i]) mdl_used[i] = 1'b0;
        mdl_count  = 0;
        mdl_taken  = 0;
        mdl_prio   = '0;
        mdl_sorted = 1'b0;

        // Empty list: list-order next, empty start, priority given with no list.
        add_row(pms_pkg::MODE_NEXT, '0, 0, 0, 0, '0, 0, 1, '0, 0, pms_pkg::ST_EMPTY);
        add_row(pms_pkg::MODE_START, '0, 0, 0, 0, '0, 1, 1, '0, 0, pms_pkg::ST_EMPTY);
        add_row(pms_pkg::MODE_NEXT, '0, 0, 0, 0, '0, 0, 1, '0, 0, pms_pkg::ST_EMPTY);
        add_row(pms_pkg::MODE_START, '0, 0, 0, 0, 32'hFFFF_FFFF, 1, 1, '0, 0,
                pms_pkg::ST_EMPTY);
        add_row(pms_pkg::MODE_NEXT, '0, 0, 0, 0, '0, 0, 1, 32'hFFFF_FFFF, 0, pms_pkg::ST_OK);
        add_row(pms_pkg::MODE_NEXT, '0, 0, 0, 0, '0, 0, 1, '0, 0, pms_pkg::ST_EMPTY);
        // Highest and lowest capture scores, a null entry, a quiet move, a tie.
        add_row(pms_pkg::MODE_APPEND, 32'hFFFF_FFFF, 1, 7, 0, '0, 0, 0, '0, 0, pms_pkg::ST_OK);
        add_row(pms_pkg::MODE_APPEND, 32'h0000_0000, 1, 7, 0, '0, 0, 0, '0, 0, pms_pkg::ST_OK);
        add_row(pms_pkg::MODE_APPEND, 32'h0000_0001, 0, 7, 7, '0, 0, 0, '0, 0, pms_pkg::ST_OK);
        add_row(pms_pkg::MODE_APPEND, 32'h8000_0000, 1, 0, 7, '0, 0, 0, '0, 0, pms_pkg::ST_OK);
        add_row(pms_pkg::MODE_APPEND, 32'h1234_5678, 1, 7, 0, '0, 0, 0, '0, 0, pms_pkg::ST_OK);
        add_row(pms_pkg::MODE_START, '0, 0, 0, 0, 32'h8000_0000, 1, 0, '0, 0, pms_pkg::ST_OK);
        repeat (5) add_row(pms_pkg::MODE_NEXT, '0, 0, 0, 0, '0, 0, 0, '0, 0, pms_pkg::ST_OK);
        // Walk the same list again in list order, past its end.
        add_row(pms_pkg::MODE_START, '0, 0, 0, 0, '0, 0, 0, '0, 0, pms_pkg::ST_OK);
        repeat (6) add_row(pms_pkg::MODE_NEXT, '0, 0, 0, 0, '0, 0, 0, '0, 0, pms_pkg::ST_OK);
        add_row(pms_pkg::MODE_CLEAR, '0, 0, 0, 0, '0, 0, 1, '0, 0, pms_pkg::ST_OK);
        add_row(pms_pkg::MODE_NEXT, '0, 0, 0, 0, '0, 0, 1, '0, 0, pms_pkg::ST_EMPTY);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i]) send_cmd(dir_tab[i].c, dir_tab[i].typed, dir_tab[i].r);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 63; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 63; end
                default: begin idle_pct = 38; stall_pct = 38; end
            endcase
            // Hold the sender off until every outstanding transaction has returned.
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
            while (got_count != sent_count) @(posedge i_clk);
            // Fill the list with appends that overflow it, then walks of four nexts each.
            if (ph == 2) run_walk(LIST_DEPTH + 2, 1'b1, 4);
            phase_end = RAND_ITEMS * (ph + 1) / 4;
            while (sent_count < phase_end) begin
                if ($urandom_range(0, 99) < 80) begin
                    run_walk($urandom_range(0, 10), $urandom_range(0, 99) < 85, -1);
                end else begin
                    repeat ($urandom_range(1, 8))
                        send_cmd(rand_cmd(2'($urandom_range(0, 3))), 1'b0, none);
                end
            end
        end

        cmd_if.valid <= 1'b0;
        while (got_count != sent_count) @(posedge i_clk);
        repeat (LIST_DEPTH + 8) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
        end
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/pms_pkg.sv
rtl/core/pms_if.sv
rtl/core/pms_ram.sv
rtl/core/priority_move_selector_top.sv
bench/priority_move_selector_top_tb.sv
